@@ rtl/core/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, limits and operation codes of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // pool geometry
  localparam int POOL_SLOTS = 256;
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int LINK_W     = SLOT_W + 1;

  // largest pool size the register accepts
  localparam int SIZE_LIMIT = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;

  // operation codes carried by func
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // one entry of the next-slot memory
  typedef struct packed {
    logic              has_next;
    logic [SLOT_W-1:0] slot;
  } link_t;

endpackage

@@ rtl/core/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size slot allocator with a LIFO free list linked through a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready with func (0 allocate, 1 free) and slot_in.
//   out channel : out_valid/out_ready with ok, slot_out and free_count, one
//                 result per request, in request order.
//   cfg channel : cfg_valid/cfg_ready with cfg_data, the pool size; a write
//                 clamps the size to 1..256 and returns every slot to free.
// A request is accepted in ST_IDLE while the next-slot RAM is read at the
// list head; in ST_EXEC the state is updated from the read data and the
// output register is loaded. The registered RAM read before a pop means the
// block takes no new request while one is in ST_EXEC.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and held until that register frees up.
// Reset sets the pool size to 256 with all slots free and an empty list.
// No clearing pass runs: a link entry is always written before it is read.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbpa_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [fbpa_pkg::SLOT_W-1:0]   slot_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [fbpa_pkg::SLOT_W-1:0]   slot_out,
  output logic [fbpa_pkg::COUNT_W-1:0]  free_count
);

  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // allocator state
  logic [COUNT_W-1:0] pool_size;
  logic [COUNT_W-1:0] untouched_left, untouched_left_next;
  logic [COUNT_W-1:0] free_total, free_total_next;
  logic [SLOT_W-1:0]  head_slot, head_slot_next;
  logic               list_nonempty, list_nonempty_next;

  // captured request
  logic              func_q;
  logic [SLOT_W-1:0] slot_q;

  // result of the current request
  logic              ok_next;
  logic [SLOT_W-1:0] slot_out_next;

  // link memory signals
  link_t link_rd, link_wr;
  logic  push;

  logic [COUNT_W-1:0] size_clamped;
  logic               in_fire, cfg_fire, out_free, exec_done;

  // handshakes: configuration wins over a request in the idle state
  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign exec_done = (state == ST_EXEC) && out_free;

  // pool size clamp
  always_comb begin
    size_clamped = cfg_data;
    if (cfg_data == '0) begin
      size_clamped = COUNT_W'(1);
    end else if (cfg_data > COUNT_W'(SIZE_LIMIT)) begin
      size_clamped = COUNT_W'(SIZE_LIMIT);
    end
  end

  // next-slot memory, read at the list head every cycle
  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (push && exec_done),
    .wr_addr (slot_q),
    .wr_data (link_wr),
    .rd_addr (head_slot),
    .rd_data (link_rd)
  );

  assign link_wr.has_next = list_nonempty;
  assign link_wr.slot     = head_slot;

  // allocate or free
  always_comb begin
    push                = 1'b0;
    ok_next             = 1'b0;
    slot_out_next       = '0;
    untouched_left_next = untouched_left;
    free_total_next     = free_total;
    head_slot_next      = head_slot;
    list_nonempty_next  = list_nonempty;
    if (func_q == FUNC_FREE) begin
      if ({1'b0, slot_q} < pool_size && free_total < pool_size) begin
        push               = 1'b1;
        ok_next            = 1'b1;
        head_slot_next     = slot_q;
        list_nonempty_next = 1'b1;
        free_total_next    = free_total + COUNT_W'(1);
      end
    end else if (free_total != '0) begin
      if (list_nonempty) begin
        ok_next            = 1'b1;
        slot_out_next      = head_slot;
        head_slot_next     = link_rd.slot;
        list_nonempty_next = link_rd.has_next;
        free_total_next    = free_total - COUNT_W'(1);
      end else if (untouched_left != '0) begin
        ok_next             = 1'b1;
        untouched_left_next = untouched_left - COUNT_W'(1);
        slot_out_next       = untouched_left_next[SLOT_W-1:0];
        free_total_next     = free_total - COUNT_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pool_size      <= COUNT_W'(SIZE_LIMIT);
      untouched_left <= COUNT_W'(SIZE_LIMIT);
      free_total     <= COUNT_W'(SIZE_LIMIT);
      head_slot      <= '0;
      list_nonempty  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        pool_size      <= size_clamped;
        untouched_left <= size_clamped;
        free_total     <= size_clamped;
        head_slot      <= '0;
        list_nonempty  <= 1'b0;
      end else if (exec_done) begin
        untouched_left <= untouched_left_next;
        free_total     <= free_total_next;
        head_slot      <= head_slot_next;
        list_nonempty  <= list_nonempty_next;
      end
      if (exec_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_q <= func;
      slot_q <= slot_in;
    end
    if (exec_done) begin
      ok         <= ok_next;
      slot_out   <= slot_out_next;
      free_count <= free_total_next;
    end
  end

  // free count never exceeds the pool
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= pool_size)
    else $error("free count above pool size");

  // pool size stays within the clamp range
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    pool_size != '0 && pool_size <= COUNT_W'(SIZE_LIMIT))
    else $error("pool size out of range");

  // an accepted free puts its slot on top of the list
  a_push_head: assert property (@(posedge clk) disable iff (rst)
    exec_done && push && !cfg_fire |=> list_nonempty && head_slot == $past(slot_q))
    else $error("freed slot not at list head");

  // a successful allocation takes exactly one free slot
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    exec_done && ok_next && func_q == FUNC_ALLOC
      |=> free_total == $past(free_total) - COUNT_W'(1))
    else $error("allocation count mismatch");

endmodule
